>>> rtl/tlpe_pkg.sv
// ----------------------------------------------------------------------------
// tlpe_pkg
// shared constants and types for the transport stream pcr extractor
// ----------------------------------------------------------------------------
package tlpe_pkg;

  localparam logic [7:0] SYNC_BYTE     = 8'h47;
  localparam logic [7:0] PCR_FLAG      = 8'h10;
  localparam logic [1:0] AFC_MASK      = 2'h3;
  localparam logic [1:0] AFC_ADAPT     = 2'd2;
  localparam logic [1:0] AFC_BOTH      = 2'd3;
  localparam logic [7:0] AF_LEN_MIN    = 8'd7;
  localparam logic [7:0] AF_LEN_MAX    = 8'd183;
  localparam logic [7:0] SHORT_PACKET  = 8'd188;
  localparam logic [7:0] LONG_PACKET   = 8'd192;
  localparam logic [7:0] PREFIX_LEN    = 8'd4;

  localparam logic [7:0] POS_SYNC      = 8'd0;
  localparam logic [7:0] POS_PID_HIGH  = 8'd1;
  localparam logic [7:0] POS_PID_LOW   = 8'd2;
  localparam logic [7:0] POS_AFC       = 8'd3;
  localparam logic [7:0] POS_AF_LEN    = 8'd4;
  localparam logic [7:0] POS_AF_FLAGS  = 8'd5;
  localparam logic [7:0] POS_PCR_FIRST = 8'd6;
  localparam logic [7:0] POS_PCR_LAST  = 8'd11;

  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  localparam logic [1:0] REG_PACKET_MODE   = 2'd0;
  localparam logic [1:0] REG_TARGET_PID    = 2'd1;
  localparam logic [1:0] REG_SEARCH_ENABLE = 2'd2;

  typedef struct packed {
    logic        packet_mode;
    logic [12:0] target_pid;
    logic        search_enable;
  } cfg_t;

  typedef struct packed {
    logic        pcr_found;
    logic [12:0] pcr_pid;
    logic [32:0] pcr_base;
    logic [8:0]  pcr_extension;
  } pcr_t;

endpackage

>>> rtl/tlpe_if.sv
// ----------------------------------------------------------------------------
// tlpe channel interfaces
// byte request channel and pcr report channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface tlpe_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_payload;

  modport source (output valid, output data_byte, output end_of_payload, input ready);
  modport sink   (input valid, input data_byte, input end_of_payload, output ready);
endinterface

interface tlpe_pcr_if;
  logic        valid;
  logic        ready;
  logic        pcr_found;
  logic [12:0] pcr_pid;
  logic [32:0] pcr_base;
  logic [8:0]  pcr_extension;

  modport source (output valid, output pcr_found, output pcr_pid, output pcr_base,
                  output pcr_extension, input ready);
  modport sink   (input valid, input pcr_found, input pcr_pid, input pcr_base,
                  input pcr_extension, output ready);
endinterface

>>> rtl/tlpe_apb_regs.sv
// ----------------------------------------------------------------------------
// tlpe_apb_regs
// apb configuration registers: packet mode, target pid, search enable
// ----------------------------------------------------------------------------
module tlpe_apb_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tlpe_pkg::ADDR_W-1:0] paddr,
  input  logic [tlpe_pkg::DATA_W-1:0] pwdata,
  output logic [tlpe_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output tlpe_pkg::cfg_t              cfg
);

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        tlpe_pkg::REG_PACKET_MODE:   cfg.packet_mode   <= pwdata[0];
        tlpe_pkg::REG_TARGET_PID:    cfg.target_pid    <= pwdata[12:0];
        tlpe_pkg::REG_SEARCH_ENABLE: cfg.search_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      tlpe_pkg::REG_PACKET_MODE:   prdata = {31'd0, cfg.packet_mode};
      tlpe_pkg::REG_TARGET_PID:    prdata = {19'd0, cfg.target_pid};
      tlpe_pkg::REG_SEARCH_ENABLE: prdata = {31'd0, cfg.search_enable};
      default:                     prdata = '0;
    endcase
  end

endmodule

>>> rtl/tlpe_scanner.sv
// ----------------------------------------------------------------------------
// tlpe_scanner
// input register plus per-packet header checks, pcr capture and commit
// ----------------------------------------------------------------------------
module tlpe_scanner (
  input  logic            clk,
  input  logic            rst,
  input  tlpe_pkg::cfg_t  cfg,
  tlpe_byte_if.sink       stream,
  output logic            res_valid,
  input  logic            res_ready,
  output tlpe_pkg::pcr_t  res
);

  logic        s_valid;
  logic [7:0]  s_byte;
  logic        s_last;
  logic        s_adv;

  logic [7:0]  pos;
  logic        header_ok;
  logic [4:0]  pid_high;
  logic [47:0] cand;
  logic        cand_valid;
  logic        com_valid;
  logic [32:0] com_base;
  logic [8:0]  com_ext;

  logic [7:0]  pos_next;
  logic        header_ok_next;
  logic [4:0]  pid_high_next;
  logic [47:0] cand_next;
  logic        cand_valid_next;
  logic        com_valid_next;
  logic [32:0] com_base_next;
  logic [8:0]  com_ext_next;

  logic [7:0]  size;
  logic [7:0]  off;
  logic [7:0]  rel;
  logic [1:0]  afc;
  logic        end_pkt;

  assign s_adv        = s_valid && (!s_last || res_ready);
  assign stream.ready = !s_valid || s_adv;
  assign res_valid    = s_valid && s_last;

  always_comb begin
    size    = cfg.packet_mode ? tlpe_pkg::LONG_PACKET : tlpe_pkg::SHORT_PACKET;
    off     = cfg.packet_mode ? tlpe_pkg::PREFIX_LEN : 8'd0;
    rel     = pos - off;
    afc     = s_byte[5:4] & tlpe_pkg::AFC_MASK;
    end_pkt = ({1'b0, pos} + 9'd1) >= {1'b0, size};

    pos_next        = pos + 8'd1;
    header_ok_next  = header_ok;
    pid_high_next   = pid_high;
    cand_next       = cand;
    cand_valid_next = cand_valid;
    com_valid_next  = com_valid;
    com_base_next   = com_base;
    com_ext_next    = com_ext;

    if (pos >= off) begin
      if (rel == tlpe_pkg::POS_SYNC) begin
        header_ok_next  = (s_byte == tlpe_pkg::SYNC_BYTE);
        cand_valid_next = 1'b0;
      end else if (rel == tlpe_pkg::POS_PID_HIGH) begin
        pid_high_next = s_byte[4:0];
      end else if (rel == tlpe_pkg::POS_PID_LOW) begin
        header_ok_next = header_ok && ({pid_high, s_byte} == cfg.target_pid);
      end else if (rel == tlpe_pkg::POS_AFC) begin
        header_ok_next = header_ok &&
                         ((afc == tlpe_pkg::AFC_ADAPT) || (afc == tlpe_pkg::AFC_BOTH));
      end else if (rel == tlpe_pkg::POS_AF_LEN) begin
        header_ok_next = header_ok && (s_byte >= tlpe_pkg::AF_LEN_MIN) &&
                         (s_byte <= tlpe_pkg::AF_LEN_MAX);
      end else if (rel == tlpe_pkg::POS_AF_FLAGS) begin
        header_ok_next = header_ok && ((s_byte & tlpe_pkg::PCR_FLAG) != 8'd0);
      end else if (rel >= tlpe_pkg::POS_PCR_FIRST && rel <= tlpe_pkg::POS_PCR_LAST) begin
        cand_next = {cand[39:0], s_byte};
        if (rel == tlpe_pkg::POS_PCR_LAST && header_ok) begin
          cand_valid_next = 1'b1;
        end
      end
    end

    if (end_pkt) begin
      if (cand_valid_next) begin
        com_valid_next = 1'b1;
        com_base_next  = cand_next[47:15];
        com_ext_next   = cand_next[8:0];
      end
      cand_valid_next = 1'b0;
      header_ok_next  = 1'b0;
      pos_next        = 8'd0;
    end

    // report uses the state after this byte
    if (com_valid_next && cfg.search_enable) begin
      res.pcr_found     = 1'b1;
      res.pcr_pid       = cfg.target_pid;
      res.pcr_base      = com_base_next;
      res.pcr_extension = com_ext_next;
    end else begin
      res = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid    <= 1'b0;
      pos        <= '0;
      header_ok  <= 1'b0;
      pid_high   <= '0;
      cand       <= '0;
      cand_valid <= 1'b0;
      com_valid  <= 1'b0;
      com_base   <= '0;
      com_ext    <= '0;
    end else begin
      if (stream.ready) begin
        s_valid <= stream.valid;
      end
      if (stream.valid && stream.ready) begin
        s_byte <= stream.data_byte;
        s_last <= stream.end_of_payload;
      end
      if (s_adv) begin
        if (s_last) begin
          pos        <= '0;
          header_ok  <= 1'b0;
          pid_high   <= '0;
          cand       <= '0;
          cand_valid <= 1'b0;
          com_valid  <= 1'b0;
          com_base   <= '0;
          com_ext    <= '0;
        end else begin
          pos        <= pos_next;
          header_ok  <= header_ok_next;
          pid_high   <= pid_high_next;
          cand       <= cand_next;
          cand_valid <= cand_valid_next;
          com_valid  <= com_valid_next;
          com_base   <= com_base_next;
          com_ext    <= com_ext_next;
        end
      end
    end
  end

endmodule

>>> rtl/tlpe_out_reg.sv
// ----------------------------------------------------------------------------
// tlpe_out_reg
// result register driving the pcr report channel
// ----------------------------------------------------------------------------
module tlpe_out_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           res_valid,
  output logic           res_ready,
  input  tlpe_pkg::pcr_t res,
  tlpe_pcr_if.source     report
);

  tlpe_pkg::pcr_t held;
  logic           valid;

  assign res_ready            = !valid || report.ready;
  assign report.valid         = valid;
  assign report.pcr_found     = held.pcr_found;
  assign report.pcr_pid       = held.pcr_pid;
  assign report.pcr_base      = held.pcr_base;
  assign report.pcr_extension = held.pcr_extension;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (res_ready) begin
      valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      held <= res;
    end
  end

endmodule

>>> rtl/ts_last_pcr_extractor.sv
// ----------------------------------------------------------------------------
// ts_last_pcr_extractor
// reports the pcr of the last complete qualifying transport stream packet
//
// stream: byte requests (data_byte, end_of_payload) under valid/ready.
// report: one pcr request per payload, issued for the byte that carries
//   end_of_payload; pcr_found is 0 and the other fields are 0 when no
//   complete packet on target_pid carried a pcr or the search is disabled.
// apb: packet_mode at 0x0, target_pid at 0x4, search_enable at 0x8.
// throughput: one byte per cycle, sustained, including across payloads, unless report stalls.
// a last byte goes through the input register, the combinational header
// logic and the result register before its pcr request appears on report.
// when report stalls, the result register holds and one further last byte
// waits in the input register; non-final bytes keep flowing until then.
// reset clears the registers, the packet state and both pipeline stages.
// ----------------------------------------------------------------------------
module ts_last_pcr_extractor (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tlpe_pkg::ADDR_W-1:0] paddr,
  input  logic [tlpe_pkg::DATA_W-1:0] pwdata,
  output logic [tlpe_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  tlpe_byte_if.sink                   stream,
  tlpe_pcr_if.source                  report
);

  tlpe_pkg::cfg_t cfg;
  tlpe_pkg::pcr_t res;
  logic           res_valid;
  logic           res_ready;

  tlpe_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tlpe_scanner u_scan (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .stream    (stream),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  tlpe_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .report    (report)
  );

  a_empty_report: assert property (@(posedge clk) disable iff (rst)
    report.valid && !report.pcr_found |->
      report.pcr_pid == 13'd0 && report.pcr_base == 33'd0 && report.pcr_extension == 9'd0)
    else $error("report without pcr carries nonzero fields");

  a_report_source: assert property (@(posedge clk) disable iff (rst)
    $rose(report.valid) |-> $past(res_valid))
    else $error("report raised without a final byte in the input register");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !stream.ready |-> res_valid && report.valid && !report.ready)
    else $error("stream stalled without a blocked report");

endmodule
